[sv/tkrs_pkg.sv]
// ---------------------------------------------------------------------------
// tkrs_pkg
// shared types and constants of the top-k row selector
// ---------------------------------------------------------------------------
package tkrs_pkg;

   // default geometry
   localparam int SLOTS_DEFAULT           = 16;
   localparam int KEY_WIDTH_DEFAULT       = 32;
   localparam int ROW_INDEX_WIDTH_DEFAULT = 32;

   // result fields
   localparam int RANK_WIDTH       = 4;
   localparam int RANKED_ROW_WIDTH = 32;

   // request commands
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // register file
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int K_LIMIT_WIDTH   = 5;

   localparam logic [K_LIMIT_WIDTH-1:0]   K_LIMIT_RESET      = 5'd16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDX_K_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDX_DESC_FIRST = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDX_DESC_SECOND = 2'd2;

   typedef enum logic {
      SEL_IDLE,
      SEL_READ
   } sel_state_type;

   // per-cell update control
   typedef struct packed {
      logic write_en;   // cell loads this cycle
      logic take_left;  // load from left neighbor, else the offered row
   } cell_ctrl_type;

endpackage

[sv/tkrs_req_if.sv]
// ---------------------------------------------------------------------------
// tkrs_req_if
// request channel: offered rows and read commands
// ---------------------------------------------------------------------------
interface tkrs_req_if #(
   parameter int KEY_WIDTH       = tkrs_pkg::KEY_WIDTH_DEFAULT,
   parameter int ROW_INDEX_WIDTH = tkrs_pkg::ROW_INDEX_WIDTH_DEFAULT
);
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [ROW_INDEX_WIDTH-1:0]  row_index;
   logic signed [KEY_WIDTH-1:0] key_first;
   logic signed [KEY_WIDTH-1:0] key_second;

   modport source (output valid, cmd, row_index, key_first, key_second, input ready);
   modport sink   (input valid, cmd, row_index, key_first, key_second, output ready);
endinterface

[sv/tkrs_rsp_if.sv]
// ---------------------------------------------------------------------------
// tkrs_rsp_if
// result channel: ranked row indexes
// ---------------------------------------------------------------------------
interface tkrs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [tkrs_pkg::RANK_WIDTH-1:0]       rank_position;
   logic [tkrs_pkg::RANKED_ROW_WIDTH-1:0] ranked_row;
   logic                                  last_of_run;

   modport source (output valid, rank_position, ranked_row, last_of_run, input ready);
   modport sink   (input valid, rank_position, ranked_row, last_of_run, output ready);
endinterface

[sv/tkrs_cell.sv]
// ---------------------------------------------------------------------------
// tkrs_cell
// one slot of the sorted chain: holds a row and compares the offered row
// ---------------------------------------------------------------------------
module tkrs_cell #(
   parameter int KEY_WIDTH       = tkrs_pkg::KEY_WIDTH_DEFAULT,
   parameter int ROW_INDEX_WIDTH = tkrs_pkg::ROW_INDEX_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic [ROW_INDEX_WIDTH-1:0]  new_row,
   input  logic signed [KEY_WIDTH-1:0] new_key_first,
   input  logic signed [KEY_WIDTH-1:0] new_key_second,
   input  logic                        desc_first,
   input  logic                        desc_second,
   input  logic                        slot_valid,
   input  logic [ROW_INDEX_WIDTH-1:0]  left_row,
   input  logic signed [KEY_WIDTH-1:0] left_key_first,
   input  logic signed [KEY_WIDTH-1:0] left_key_second,
   input  tkrs_pkg::cell_ctrl_type     ctrl,
   output logic [ROW_INDEX_WIDTH-1:0]  row,
   output logic signed [KEY_WIDTH-1:0] key_first,
   output logic signed [KEY_WIDTH-1:0] key_second,
   output logic                        new_before
);
   import tkrs_pkg::*;

   logic [ROW_INDEX_WIDTH-1:0]  row_ff;
   logic signed [KEY_WIDTH-1:0] key_first_ff;
   logic signed [KEY_WIDTH-1:0] key_second_ff;

   logic first_lt, first_eq, first_before;
   logic second_lt, second_eq, second_before;

   always_comb begin
      first_lt      = new_key_first < key_first_ff;
      first_eq      = new_key_first == key_first_ff;
      first_before  = desc_first ? (!first_lt && !first_eq) : first_lt;
      second_lt     = new_key_second < key_second_ff;
      second_eq     = new_key_second == key_second_ff;
      second_before = desc_second ? (!second_lt && !second_eq) : second_lt;
      // empty slot orders after everything; full tie goes to the smaller index
      new_before = !slot_valid || first_before ||
                   (first_eq && (second_before || (second_eq && (new_row < row_ff))));
   end

   always_ff @(posedge clock) begin
      if (ctrl.write_en) begin
         if (ctrl.take_left) begin
            row_ff        <= left_row;
            key_first_ff  <= left_key_first;
            key_second_ff <= left_key_second;
         end else begin
            row_ff        <= new_row;
            key_first_ff  <= new_key_first;
            key_second_ff <= new_key_second;
         end
      end
   end

   assign row        = row_ff;
   assign key_first  = key_first_ff;
   assign key_second = key_second_ff;

endmodule

[sv/top_k_row_selector.sv]
// ---------------------------------------------------------------------------
// top_k_row_selector
// keeps the best k offered rows in a sorted chain of cells and reads them out
// ---------------------------------------------------------------------------
//  channel | dir | handshake            | content
//  req     | in  | valid / ready        | cmd, row_index, key_first, key_second
//  rsp     | out | valid / ready        | rank_position, ranked_row, last_of_run
//  csr     | in  | psel/penable, pready | k_limit, desc_first, desc_second
//
//  on a push all cells compare against the offered row at once
//  and the rows behind the insert point shift one cell down the chain
//  a read is accepted while idle and then gives one result per held row, one
//  result per cycle through the output register; rsp.ready low holds the readout
//  req.ready is low only while a readout is in progress
//  reset clears the held count and registers; cell contents are not cleared
// ---------------------------------------------------------------------------
module top_k_row_selector #(
   parameter int SLOTS           = tkrs_pkg::SLOTS_DEFAULT,
   parameter int KEY_WIDTH       = tkrs_pkg::KEY_WIDTH_DEFAULT,
   parameter int ROW_INDEX_WIDTH = tkrs_pkg::ROW_INDEX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   tkrs_req_if.sink                            req,
   tkrs_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tkrs_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [tkrs_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [tkrs_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import tkrs_pkg::*;

   // count holds 0..SLOTS
   localparam int CW = $clog2(SLOTS + 1);

   // ---------------------------------------------------------------- registers
   logic [K_LIMIT_WIDTH-1:0] k_limit_ff;
   logic                     desc_first_ff;
   logic                     desc_second_ff;

   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic                       csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_limit_ff     <= K_LIMIT_RESET;
         desc_first_ff  <= 1'b0;
         desc_second_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IDX_K_LIMIT:     k_limit_ff     <= pwdata[K_LIMIT_WIDTH-1:0];
            CSR_IDX_DESC_FIRST:  desc_first_ff  <= pwdata[0];
            CSR_IDX_DESC_SECOND: desc_second_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_IDX_K_LIMIT:     prdata = CSR_DATA_WIDTH'(k_limit_ff);
         CSR_IDX_DESC_FIRST:  prdata = CSR_DATA_WIDTH'(desc_first_ff);
         CSR_IDX_DESC_SECOND: prdata = CSR_DATA_WIDTH'(desc_second_ff);
         default:             prdata = '0;
      endcase
   end

   // effective k: zero counts as one, clipped to the chain length
   logic [CW-1:0] k_eff;

   always_comb begin
      if (k_limit_ff == '0) begin
         k_eff = CW'(1);
      end else if (32'(k_limit_ff) > SLOTS) begin
         k_eff = CW'(SLOTS);
      end else begin
         k_eff = CW'(k_limit_ff);
      end
   end

   // ---------------------------------------------------------------- control
   sel_state_type state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic          req_ready;
   logic          push_go;
   logic          read_go;
   logic          grow;
   logic          out_free;
   logic          load;

   assign req_ready = (state_ff == SEL_IDLE);
   assign req.ready = req_ready;
   assign push_go   = req.valid && req_ready && (req.cmd == CMD_PUSH);
   assign read_go   = req.valid && req_ready && (req.cmd == CMD_READ);
   assign grow      = count_ff < k_eff;
   assign out_free  = !rsp.valid || rsp.ready;

   // ---------------------------------------------------------------- cell chain
   logic [ROW_INDEX_WIDTH-1:0]  cell_row        [SLOTS];
   logic signed [KEY_WIDTH-1:0] cell_key_first  [SLOTS];
   logic signed [KEY_WIDTH-1:0] cell_key_second [SLOTS];
   logic                        cell_before     [SLOTS];
   logic                        cell_tail       [SLOTS];
   cell_ctrl_type               cell_ctrl       [SLOTS];
   logic                        replace_ok;

   // full store: the offered row must order before the current worst row
   always_comb begin
      replace_ok = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (CW'(i + 1) == count_ff) begin
            replace_ok = cell_before[i];
         end
      end
   end

   // held rows keep their places when the sort directions change, so the
   // insert point is the start of the unbroken run of losing cells at the tail
   // (empty cells always lose)
   always_comb begin
      cell_tail[SLOTS-1] = cell_before[SLOTS-1];
      for (int i = SLOTS - 2; i >= 0; i--) begin
         cell_tail[i] = cell_before[i] && cell_tail[i+1];
      end
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      logic                        left_before;
      logic [ROW_INDEX_WIDTH-1:0]  left_row;
      logic signed [KEY_WIDTH-1:0] left_key_first;
      logic signed [KEY_WIDTH-1:0] left_key_second;
      logic                        in_range;

      if (g == 0) begin : g_head
         // head of the chain has no left neighbor
         assign left_before     = 1'b0;
         assign left_row        = req.row_index;
         assign left_key_first  = req.key_first;
         assign left_key_second = req.key_second;
      end else begin : g_body
         assign left_before     = cell_tail[g-1];
         assign left_row        = cell_row[g-1];
         assign left_key_first  = cell_key_first[g-1];
         assign left_key_second = cell_key_second[g-1];
      end

      // growing uses one more slot; replacing drops the last held row
      assign in_range = grow ? (CW'(g) <= count_ff) : ((CW'(g) < count_ff) && replace_ok);
      assign cell_ctrl[g].write_en  = push_go && cell_tail[g] && in_range;
      assign cell_ctrl[g].take_left = left_before;

      tkrs_cell #(
         .KEY_WIDTH       (KEY_WIDTH),
         .ROW_INDEX_WIDTH (ROW_INDEX_WIDTH)
      ) u_cell (
         .clock           (clock),
         .new_row         (req.row_index),
         .new_key_first   (req.key_first),
         .new_key_second  (req.key_second),
         .desc_first      (desc_first_ff),
         .desc_second     (desc_second_ff),
         .slot_valid      (CW'(g) < count_ff),
         .left_row        (left_row),
         .left_key_first  (left_key_first),
         .left_key_second (left_key_second),
         .ctrl            (cell_ctrl[g]),
         .row             (cell_row[g]),
         .key_first       (cell_key_first[g]),
         .key_second      (cell_key_second[g]),
         .new_before      (cell_before[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push_go && grow) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   // ---------------------------------------------------------------- readout
   logic [ROW_INDEX_WIDTH-1:0] rd_row;
   logic [63:0]                rd_row_wide;
   logic                       rd_last;

   // select the cell at the readout position
   always_comb begin
      rd_row = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (CW'(i) == idx_ff) begin
            rd_row = cell_row[i];
         end
      end
   end

   assign rd_row_wide = 64'(rd_row);
   assign rd_last     = (idx_ff + CW'(1)) == count_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      load     = 1'b0;
      case (state_ff)
         SEL_IDLE: begin
            // read of an empty store gives nothing
            if (read_go && (count_ff != '0)) begin
               state_in = SEL_READ;
               idx_in   = '0;
            end
         end
         SEL_READ: begin
            if (out_free) begin
               load   = 1'b1;
               idx_in = idx_ff + CW'(1);
               if (rd_last) begin
                  state_in = SEL_IDLE;
               end
            end
         end
         default: state_in = SEL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // ---------------------------------------------------------------- output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RANK_WIDTH-1:0]       rank_ff;
   logic [RANKED_ROW_WIDTH-1:0] ranked_row_ff;
   logic                        last_ff;

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rank_ff       <= RANK_WIDTH'(idx_ff);
         ranked_row_ff <= rd_row_wide[RANKED_ROW_WIDTH-1:0];
         last_ff       <= rd_last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.rank_position = rank_ff;
   assign rsp.ranked_row    = ranked_row_ff;
   assign rsp.last_of_run   = last_ff;

endmodule

[sv/tkrs_checker.sv]
// ---------------------------------------------------------------------------
// tkrs_checker
// port-level checks of the top-k row selector
// ---------------------------------------------------------------------------
module tkrs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tkrs_pkg::RANK_WIDTH-1:0]   rsp_rank_position,
   input logic [tkrs_pkg::RANKED_ROW_WIDTH-1:0] rsp_ranked_row,
   input logic                              rsp_last_of_run,
   input logic                              pready
);
   import tkrs_pkg::*;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rank_position) &&
      $stable(rsp_ranked_row) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // no request taken while a readout is unfinished
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("request accepted during readout");

   // a readout continues without gaps with the next rank
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
      rsp_valid && (rsp_rank_position == RANK_WIDTH'($past(rsp_rank_position) + 1'b1)))
      else $error("readout rank sequence broken");

   // register port never waits
   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind top_k_row_selector tkrs_checker u_tkrs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_rank_position (rsp.rank_position),
   .rsp_ranked_row    (rsp.ranked_row),
   .rsp_last_of_run   (rsp.last_of_run),
   .pready            (pready)
);
